/* design/tgc_pkg.sv */
// Shared types, codes and sizes of the touch gesture classifier.
package tgc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int TIME_BITS     = 32;
    localparam int THRESH_BITS   = 7;
    localparam int MS_BITS       = 16;
    localparam int SCREEN_BITS   = 15;
    localparam int SPEED_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Percentage scale and products compared in the swipe test
    localparam int PCT_SCALE  = 100;
    localparam int SCALE_BITS = 7;
    localparam int THR_W      = THRESH_BITS + SCREEN_BITS;
    localparam int PROD_W     = (COORD_BITS + SCALE_BITS > THR_W) ?
                                (COORD_BITS + SCALE_BITS) : THR_W;

    // Speed divider: dividend is distance scaled by 256, one quotient bit a step
    localparam int FRAC_BITS    = 8;
    localparam int DIV_STEPS    = COORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_PTR_BITS = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);

    typedef logic [1:0] t_op;
    localparam t_op OP_BEGIN = 2'd0;
    localparam t_op OP_MOVE  = 2'd1;
    localparam t_op OP_END   = 2'd2;
    localparam t_op OP_TICK  = 2'd3;

    typedef logic [2:0] t_gesture;
    localparam t_gesture G_NONE   = 3'd0;
    localparam t_gesture G_SWIPE  = 3'd1;
    localparam t_gesture G_SINGLE = 3'd2;
    localparam t_gesture G_DOUBLE = 3'd3;
    localparam t_gesture G_LONG   = 3'd4;

    typedef logic [1:0] t_dir;
    localparam t_dir DIR_RIGHT = 2'd0;
    localparam t_dir DIR_LEFT  = 2'd1;
    localparam t_dir DIR_DOWN  = 2'd2;
    localparam t_dir DIR_UP    = 2'd3;

    typedef logic [CFG_IDX_BITS-1:0] t_reg_idx;
    localparam t_reg_idx REG_THRESH     = 3'd0;
    localparam t_reg_idx REG_SWIPE_TIME = 3'd1;
    localparam t_reg_idx REG_LONG_TIME  = 3'd2;
    localparam t_reg_idx REG_DTAP_TIME  = 3'd3;
    localparam t_reg_idx REG_WIDTH      = 3'd4;
    localparam t_reg_idx REG_HEIGHT     = 3'd5;

    typedef struct packed {
        logic [THRESH_BITS-1:0] thresh;
        logic [MS_BITS-1:0]     swipe_time;
        logic [MS_BITS-1:0]     long_time;
        logic [MS_BITS-1:0]     dtap_time;
        logic [SCREEN_BITS-1:0] width;
        logic [SCREEN_BITS-1:0] height;
    } t_cfg;

    typedef struct packed {
        t_gesture                      gesture;
        t_dir                          dir;
        logic [COORD_BITS-1:0]         travel;
        logic [TIME_BITS-1:0]          dt;
        logic signed [COORD_BITS-1:0]  wx;
        logic signed [COORD_BITS-1:0]  wy;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_DECIDE
    } t_fstate;

    typedef enum logic {
        B_IDLE,
        B_DIV
    } t_bstate;

endpackage

/* design/tgc_front.sv */
// Front end: takes touch events, keeps gesture state and issues result requests.
module tgc_front import tgc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  t_op                           i_opcode,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic [TIME_BITS-1:0]          i_time_ms,
    input  t_cfg                          i_cfg,
    input  t_qstat                        i_qstat,
    output logic                          o_cmd_push,
    output t_cmd                          o_cmd
);

    t_fstate r_state, n_state;

    // Latched event
    t_op                          r_op;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [TIME_BITS-1:0]         r_now;

    // Differences worked out in the calc cycle
    logic [COORD_BITS-1:0] r_ax, r_ay;
    logic                  r_dx_neg, r_dy_neg;
    logic [TIME_BITS-1:0]  r_dt;
    logic [THR_W-1:0]      r_thr_w, r_thr_h;

    // Gesture state
    logic signed [COORD_BITS-1:0] r_start_x, r_start_y, r_end_x, r_end_y;
    logic [TIME_BITS-1:0]         r_start_time, r_deadline;
    logic                         r_win_open, r_moved, r_swiped;
    logic [1:0]                   r_taps;

    logic [COORD_BITS:0]   w_dx, w_dy, w_dx_abs, w_dy_abs;
    logic [PROD_W-1:0]     w_ax100, w_ay100;
    logic                  w_fast, w_horiz, w_vert, w_long, w_due;
    logic [TIME_BITS-1:0]  w_late;
    logic                  w_need, w_commit;
    t_cmd                  w_cmd;

    assign w_dx = {r_start_x[COORD_BITS-1], r_start_x} - {r_px[COORD_BITS-1], r_px};
    assign w_dy = {r_start_y[COORD_BITS-1], r_start_y} - {r_py[COORD_BITS-1], r_py};
    assign w_dx_abs = w_dx[COORD_BITS] ? (~w_dx + 1'b1) : w_dx;
    assign w_dy_abs = w_dy[COORD_BITS] ? (~w_dy + 1'b1) : w_dy;

    assign w_ax100 = PROD_W'(r_ax) * PROD_W'(PCT_SCALE);
    assign w_ay100 = PROD_W'(r_ay) * PROD_W'(PCT_SCALE);
    assign w_fast  = r_dt < TIME_BITS'(i_cfg.swipe_time);
    assign w_horiz = (r_ax > r_ay) && (w_ax100 > PROD_W'(r_thr_w)) && w_fast;
    assign w_vert  = (r_ay > r_ax) && (w_ay100 > PROD_W'(r_thr_h)) && w_fast;
    assign w_long  = r_dt >= TIME_BITS'(i_cfg.long_time);
    assign w_late  = r_now - r_deadline;
    assign w_due   = r_win_open && !w_late[TIME_BITS-1];

    // Decode the event into an optional result request
    always_comb begin
        w_need = 1'b0;
        w_cmd  = '0;
        unique case (r_op)
            OP_BEGIN: begin
                w_need = 1'b0;
            end
            OP_MOVE: begin
                w_need      = !r_swiped && (w_horiz || w_vert);
                w_cmd.gesture = G_SWIPE;
                w_cmd.dt      = r_dt;
                if (w_horiz) begin
                    w_cmd.dir    = r_dx_neg ? DIR_RIGHT : DIR_LEFT;
                    w_cmd.travel = r_ax;
                end else begin
                    w_cmd.dir    = r_dy_neg ? DIR_UP : DIR_DOWN;
                    w_cmd.travel = r_ay;
                end
            end
            OP_END: begin
                w_need        = w_long;
                w_cmd.gesture = G_LONG;
                w_cmd.wx      = r_px;
                w_cmd.wy      = r_py;
            end
            OP_TICK: begin
                w_need        = w_due && (((r_taps == 2'd1) && !r_moved) || (r_taps == 2'd2));
                w_cmd.gesture = (r_taps == 2'd2) ? G_DOUBLE : G_SINGLE;
                w_cmd.wx      = r_end_x;
                w_cmd.wy      = r_end_y;
            end
            default: begin
                w_need = 1'b0;
            end
        endcase
    end

    assign w_commit = (r_state == F_DECIDE) && (!w_need || !i_qstat.full);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:   if (i_push) n_state = F_CALC;
            F_CALC:   n_state = F_DECIDE;
            F_DECIDE: if (w_commit) n_state = F_IDLE;
            default:  n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_full     = (r_state != F_IDLE);
        o_cmd_push = w_commit && w_need;
        o_cmd      = w_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_op  <= i_opcode;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_now <= i_time_ms;
        end
        if (r_state == F_CALC) begin
            r_ax     <= w_dx_abs[COORD_BITS-1:0];
            r_ay     <= w_dy_abs[COORD_BITS-1:0];
            r_dx_neg <= w_dx[COORD_BITS];
            r_dy_neg <= w_dy[COORD_BITS];
            r_dt     <= r_now - r_start_time;
            r_thr_w  <= THR_W'(i_cfg.thresh) * THR_W'(i_cfg.width);
            r_thr_h  <= THR_W'(i_cfg.thresh) * THR_W'(i_cfg.height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_end_x      <= '0;
            r_end_y      <= '0;
            r_start_time <= '0;
            r_deadline   <= '0;
            r_win_open   <= 1'b0;
            r_moved      <= 1'b0;
            r_swiped     <= 1'b0;
            r_taps       <= '0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                case (r_op)
                    OP_BEGIN: begin
                        r_start_x    <= r_px;
                        r_start_y    <= r_py;
                        r_start_time <= r_now;
                        r_moved      <= 1'b0;
                        r_swiped     <= 1'b0;
                    end
                    OP_MOVE: begin
                        r_moved <= 1'b1;
                        if (w_need) r_swiped <= 1'b1;
                    end
                    OP_END: begin
                        r_end_x  <= r_px;
                        r_end_y  <= r_py;
                        r_swiped <= 1'b0;
                        if (!w_long) begin
                            // first tap opens the collection window
                            if (r_taps == 2'd0) begin
                                r_start_time <= r_now;
                                r_deadline   <= r_now + TIME_BITS'(i_cfg.dtap_time);
                                r_win_open   <= 1'b1;
                            end
                            if (r_taps != 2'd3) r_taps <= r_taps + 2'd1;
                        end
                    end
                    default: begin
                        if (w_due) begin
                            r_win_open <= 1'b0;
                            r_taps     <= '0;
                        end
                    end
                endcase
            end
        end
    end

    ast_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> o_full)
        else $error("front took a request without going busy");

    ast_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_qstat.full)
        else $error("front pushed into a full command queue");

endmodule

/* design/tgc_cmdq.sv */
// Short command queue between the front end and the result stage.
module tgc_cmdq import tgc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_qstat o_stat
);

    t_cmd                     r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_BITS-1:0] r_wptr, r_rptr;
    logic [CMDQ_CNT_BITS-1:0] r_count;

    function automatic logic [CMDQ_PTR_BITS-1:0] ptr_inc(input logic [CMDQ_PTR_BITS-1:0] p);
        ptr_inc = (p == CMDQ_PTR_BITS'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_cmd       = r_mem[r_rptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CMDQ_CNT_BITS'(CMDQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= ptr_inc(r_wptr);
            if (i_pop)  r_rptr <= ptr_inc(r_rptr);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    ast_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CMDQ_CNT_BITS'(CMDQ_DEPTH))
        else $error("command queue count beyond depth");

endmodule

/* design/tgc_back.sv */
// Result stage: works out swipe speed by restoring division and holds the result.
module tgc_back import tgc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  t_qstat                        i_qstat,
    output logic                          o_cmd_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output t_gesture                      o_gesture,
    output t_dir                          o_direction,
    output logic [COORD_BITS-1:0]         o_distance,
    output logic [SPEED_BITS-1:0]         o_speed,
    output logic signed [COORD_BITS-1:0]  o_where_x,
    output logic signed [COORD_BITS-1:0]  o_where_y
);

    t_bstate r_state, n_state;

    logic                    r_out_valid;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [TIME_BITS-1:0]    r_den, r_rem;
    logic [DIV_STEPS-1:0]    r_num, r_quo;
    t_dir                    r_dir;
    logic [COORD_BITS-1:0]   r_dist;

    logic                    w_take, w_divide, w_load_direct, w_load_div, w_last;
    logic [TIME_BITS:0]      w_trial, w_diff;
    logic                    w_qbit;
    logic [TIME_BITS-1:0]    w_rem_next;
    logic [DIV_STEPS-1:0]    w_quo_next;
    logic [SPEED_BITS-1:0]   w_speed;

    assign w_trial    = {r_rem, r_num[DIV_STEPS-1]};
    assign w_diff     = w_trial - {1'b0, r_den};
    assign w_qbit     = !w_diff[TIME_BITS];
    assign w_rem_next = w_qbit ? w_diff[TIME_BITS-1:0] : w_trial[TIME_BITS-1:0];
    assign w_quo_next = {r_quo[DIV_STEPS-2:0], w_qbit};
    assign w_last     = (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));
    // saturate when the quotient spills over the Q8.8 range
    assign w_speed    = (|w_quo_next[DIV_STEPS-1:SPEED_BITS]) ? '1 :
                        w_quo_next[SPEED_BITS-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (w_divide) n_state = B_DIV;
            B_DIV:   if (w_last) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        w_take        = (r_state == B_IDLE) && !i_qstat.empty && !r_out_valid;
        w_divide      = w_take && (i_cmd.gesture == G_SWIPE) && (i_cmd.dt != '0);
        w_load_direct = w_take && !w_divide;
        w_load_div    = (r_state == B_DIV) && w_last;
        o_cmd_pop     = w_take;
        o_empty       = !r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_divide) begin
            r_den  <= i_cmd.dt;
            r_num  <= {i_cmd.travel, FRAC_BITS'(0)};
            r_rem  <= '0;
            r_quo  <= '0;
            r_dir  <= i_cmd.dir;
            r_dist <= i_cmd.travel;
        end else if (r_state == B_DIV) begin
            r_num <= {r_num[DIV_STEPS-2:0], 1'b0};
            r_rem <= w_rem_next;
            r_quo <= w_quo_next;
        end
        if (w_load_direct) begin
            o_gesture   <= i_cmd.gesture;
            o_direction <= i_cmd.dir;
            o_distance  <= i_cmd.travel;
            // a swipe with no elapsed time reads as full speed
            o_speed     <= (i_cmd.gesture == G_SWIPE) ? '1 : '0;
            o_where_x   <= i_cmd.wx;
            o_where_y   <= i_cmd.wy;
        end else if (w_load_div) begin
            o_gesture   <= G_SWIPE;
            o_direction <= r_dir;
            o_distance  <= r_dist;
            o_speed     <= w_speed;
            o_where_x   <= '0;
            o_where_y   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (w_load_direct || w_load_div) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (w_divide) begin
                r_cnt <= '0;
            end else if (r_state == B_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    ast_slot_free_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> !r_out_valid)
        else $error("result held while the divider runs");

    ast_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV && w_last) |=> (r_state == B_IDLE && r_out_valid))
        else $error("divider finished without a result");

endmodule

/* design/touch_gesture_classifier_unit.sv */
// Top level of the touch gesture classifier: configuration registers and wiring.
//
//  channel  | signals                                   | request moves on
//  ---------+-------------------------------------------+--------------------------
//  events   | push full i_opcode i_pos_x i_pos_y i_time_ms | push high, full low
//  results  | empty pop o_gesture .. o_where_y          | pop high, empty low
//  config   | i_cfg_we i_cfg_idx i_cfg_data             | i_cfg_we high
//
// Every event passes through the front end as latch, differences and decide;
// full is high while the differences and decide steps run, and longer while a
// result waits for room in a full command queue.
// A swipe with non-zero elapsed time goes through the speed divider, one quotient
// bit a cycle; other results are loaded straight into the output register.
// Reset is synchronous and active low; it restores the default configuration.
// The front end keeps taking events while the result stage divides or a result
// waits to be popped, up to the two-entry command queue.
module touch_gesture_classifier_unit import tgc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_opcode,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic [TIME_BITS-1:0]          i_time_ms,
    output logic                          empty,
    input  logic                          pop,
    output logic [2:0]                    o_gesture,
    output logic [1:0]                    o_direction,
    output logic [COORD_BITS-1:0]         o_distance,
    output logic [SPEED_BITS-1:0]         o_speed,
    output logic signed [COORD_BITS-1:0]  o_where_x,
    output logic signed [COORD_BITS-1:0]  o_where_y,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    t_cfg   r_cfg;
    t_cmd   w_push_cmd, w_head_cmd;
    logic   w_cmd_push, w_cmd_pop;
    t_qstat w_qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh     <= THRESH_BITS'(10);
            r_cfg.swipe_time <= MS_BITS'(500);
            r_cfg.long_time  <= MS_BITS'(1000);
            r_cfg.dtap_time  <= MS_BITS'(10);
            r_cfg.width      <= SCREEN_BITS'(1024);
            r_cfg.height     <= SCREEN_BITS'(768);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESH:     r_cfg.thresh     <= i_cfg_data[THRESH_BITS-1:0];
                REG_SWIPE_TIME: r_cfg.swipe_time <= i_cfg_data[MS_BITS-1:0];
                REG_LONG_TIME:  r_cfg.long_time  <= i_cfg_data[MS_BITS-1:0];
                REG_DTAP_TIME:  r_cfg.dtap_time  <= i_cfg_data[MS_BITS-1:0];
                REG_WIDTH:      r_cfg.width      <= i_cfg_data[SCREEN_BITS-1:0];
                REG_HEIGHT:     r_cfg.height     <= i_cfg_data[SCREEN_BITS-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    tgc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_opcode   (i_opcode),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_time_ms  (i_time_ms),
        .i_cfg      (r_cfg),
        .i_qstat    (w_qstat),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_push_cmd)
    );

    tgc_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_qstat)
    );

    tgc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_qstat     (w_qstat),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_gesture   (o_gesture),
        .o_direction (o_direction),
        .o_distance  (o_distance),
        .o_speed     (o_speed),
        .o_where_x   (o_where_x),
        .o_where_y   (o_where_y)
    );

endmodule
